// ----- rtl/ppp_pkg.sv -----
// ---------------------------------------------------------------------------
// ppp_pkg - shared types and constants for the pinhole point projection
// Fixed-point format, divider width and the records carried down the cells.
// ---------------------------------------------------------------------------
`default_nettype none
package ppp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_W     = 64;
  localparam int CELLS     = NUM_W;
  localparam logic [31:0] FOCAL_RESET = 32'(1) << FRAC_BITS;

  localparam logic [7:0] REG_FOCAL_X  = 8'd0;
  localparam logic [7:0] REG_FOCAL_Y  = 8'd1;
  localparam logic [7:0] REG_CENTER_X = 8'd2;
  localparam logic [7:0] REG_CENTER_Y = 8'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic CMD_BACK = 1'b0;

  typedef struct packed {
    logic [31:0] focal_x;
    logic [31:0] focal_y;
    logic [31:0] center_x;
    logic [31:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [31:0]      rem;
    logic [31:0]      den;
  } lane_t;

  typedef struct packed {
    logic        zero;
    logic        neg_a;
    logic        neg_b;
    logic [31:0] off_a;
    logic [31:0] off_b;
    logic [31:0] depth;
    logic [23:0] color;
  } side_t;

  typedef struct packed {
    lane_t a;
    lane_t b;
    side_t side;
  } stage_t;

endpackage
`default_nettype wire

// ----- rtl/ppp_front.sv -----
// ---------------------------------------------------------------------------
// ppp_front - operand set-up
// Forms both exact products, divisors and signs, then adds half the divisor.
// ---------------------------------------------------------------------------
`default_nettype none
module ppp_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic            cmd,
  input  wire logic [31:0]     coord_a,
  input  wire logic [31:0]     coord_b,
  input  wire logic [31:0]     depth,
  input  wire logic [23:0]     color,
  input  wire ppp_pkg::cfg_t   cfg,
  output logic                 out_valid,
  output ppp_pkg::stage_t      out_stage
);
  import ppp_pkg::*;

  typedef struct packed {
    logic [NUM_W-1:0] prod_a;
    logic [NUM_W-1:0] prod_b;
    logic [31:0]      den_a;
    logic [31:0]      den_b;
    side_t            side;
  } prod_t;

  logic        back;
  logic [31:0] dmag;
  logic [31:0] fx, fy;
  logic signed [32:0] m1a, m1b;
  logic [32:0] ma, mb;
  logic [31:0] m2a, m2b;
  logic [64:0] pa, pb;
  prod_t       p_next, p;
  logic        p_valid;

  always_comb begin
    back = (cmd == CMD_BACK);
    dmag = depth[31] ? 32'(-depth) : depth;
    fx   = (cfg.focal_x == 32'd0) ? 32'd1 : cfg.focal_x;
    fy   = (cfg.focal_y == 32'd0) ? 32'd1 : cfg.focal_y;
    m1a  = back ? ($signed({coord_a[31], coord_a}) - $signed({cfg.center_x[31], cfg.center_x}))
                : $signed({coord_a[31], coord_a});
    m1b  = back ? ($signed({coord_b[31], coord_b}) - $signed({cfg.center_y[31], cfg.center_y}))
                : $signed({coord_b[31], coord_b});
    ma   = m1a[32] ? 33'(-m1a) : 33'(m1a);
    mb   = m1b[32] ? 33'(-m1b) : 33'(m1b);
    m2a  = back ? dmag : cfg.focal_x;
    m2b  = back ? dmag : cfg.focal_y;
    pa   = {32'd0, ma} * {33'd0, m2a};
    pb   = {32'd0, mb} * {33'd0, m2b};
    p_next.prod_a     = pa[NUM_W-1:0];
    p_next.prod_b     = pb[NUM_W-1:0];
    p_next.den_a      = back ? fx : dmag;
    p_next.den_b      = back ? fy : dmag;
    p_next.side.zero  = !back && (depth == 32'd0);
    p_next.side.neg_a = m1a[32] ^ depth[31];
    p_next.side.neg_b = m1b[32] ^ depth[31];
    p_next.side.off_a = back ? 32'd0 : cfg.center_x;
    p_next.side.off_b = back ? 32'd0 : cfg.center_y;
    p_next.side.depth = depth;
    p_next.side.color = color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= in_valid;
      out_valid <= p_valid;
    end
    if (en) begin
      p <= p_next;
      out_stage.a.num <= p.prod_a + {32'd0, 1'b0, p.den_a[31:1]};
      out_stage.a.rem <= 32'd0;
      out_stage.a.den <= p.den_a;
      out_stage.b.num <= p.prod_b + {32'd0, 1'b0, p.den_b[31:1]};
      out_stage.b.rem <= 32'd0;
      out_stage.b.den <= p.den_b;
      out_stage.side  <= p.side;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ppp_cell.sv -----
// ---------------------------------------------------------------------------
// ppp_cell - one restoring division step for both lanes
// Shifts one numerator bit into the remainder and one quotient bit out.
// ---------------------------------------------------------------------------
`default_nettype none
module ppp_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire ppp_pkg::stage_t  in_stage,
  output logic                  out_valid,
  output ppp_pkg::stage_t       out_stage
);
  import ppp_pkg::*;

  function automatic lane_t step(lane_t l);
    logic [32:0] t;
    logic        ge;
    lane_t       r;
    t  = {l.rem, l.num[NUM_W-1]};
    ge = t >= {1'b0, l.den};
    r.rem = ge ? 32'(t - {1'b0, l.den}) : t[31:0];
    r.num = {l.num[NUM_W-2:0], ge};
    r.den = l.den;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_stage.a    <= step(in_stage.a);
      out_stage.b    <= step(in_stage.b);
      out_stage.side <= in_stage.side;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ppp_back.sv -----
// ---------------------------------------------------------------------------
// ppp_back - sign, clamp, offset and saturation; output register
// ---------------------------------------------------------------------------
`default_nettype none
module ppp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire ppp_pkg::stage_t  in_stage,
  output logic                  out_valid,
  output logic [31:0]           out_a,
  output logic [31:0]           out_b,
  output logic [31:0]           out_depth,
  output logic [23:0]           out_color,
  output logic [1:0]            status
);
  import ppp_pkg::*;

  function automatic logic [32:0] finish(logic [NUM_W-1:0] q, logic neg, logic [31:0] off);
    logic [40:0]        qc;
    logic signed [42:0] v;
    logic               sat;
    logic [31:0]        r;
    qc = ((|q[NUM_W-1:41]) || (q[40] && (|q[39:0]))) ? {1'b1, 40'd0} : q[40:0];
    v  = neg ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
    v  = v + $signed({{11{off[31]}}, off});
    sat = 1'b1;
    if (v > 43'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -43'sd2147483648) r = 32'h8000_0000;
    else begin
      r   = v[31:0];
      sat = 1'b0;
    end
    return {sat, r};
  endfunction

  logic [32:0] ra, rb;

  always_comb begin
    ra = finish(in_stage.a.num, in_stage.side.neg_a, in_stage.side.off_a);
    rb = finish(in_stage.b.num, in_stage.side.neg_b, in_stage.side.off_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_depth <= in_stage.side.depth;
      out_color <= in_stage.side.color;
      if (in_stage.side.zero) begin
        out_a  <= 32'd0;
        out_b  <= 32'd0;
        status <= ST_ZERO;
      end else begin
        out_a  <= ra[31:0];
        out_b  <= rb[31:0];
        status <= (ra[32] || rb[32]) ? ST_SAT : ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pinhole_point_projection.sv -----
// ---------------------------------------------------------------------------
// pinhole_point_projection - pinhole camera projection and back-projection
//
// Input stream s_*: one point per beat. s_tuser carries cmd (0 image to
// camera, 1 camera to image); s_tdata carries coord_a, coord_b, depth and
// color. Output stream m_*: one result per beat, m_tdata with out_a, out_b,
// out_depth, out_color and m_tuser with status.
// Configuration channel cfg_*: index 0 focal_x, 1 focal_y, 2 center_x,
// 3 center_y; other indices are ignored. cfg_ready is always high; write
// only while no point is in flight.
// The path is two set-up stages (multiply, rounding add), one cell per
// quotient bit of the 64-bit restoring divider, and the output register.
// One point is taken every cycle while the chain is not held.
// When m_tready is low with a result waiting, the whole chain holds and
// s_tready drops until the waiting beat is taken.
// Reset clears all valid flags and sets focal lengths to 1.0, centres to 0.
// ---------------------------------------------------------------------------
`default_nettype none
module pinhole_point_projection (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [119:0]  s_tdata,   // coord_a, coord_b, depth, color
  input  wire logic          s_tuser,   // cmd
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [119:0]       m_tdata,   // out_a, out_b, out_depth, out_color
  output logic [1:0]         m_tuser,   // status
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [7:0]    cfg_index,
  input  wire logic [31:0]   cfg_data
);
  import ppp_pkg::*;

  cfg_t   cfg;
  logic   en;
  logic   v [0:CELLS];
  stage_t st [0:CELLS];
  logic [31:0] oa, ob, od;
  logic [23:0] oc;

  assign cfg_ready = 1'b1;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x  <= FOCAL_RESET;
      cfg.focal_y  <= FOCAL_RESET;
      cfg.center_x <= 32'd0;
      cfg.center_y <= 32'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FOCAL_X:  cfg.focal_x  <= cfg_data;
        REG_FOCAL_Y:  cfg.focal_y  <= cfg_data;
        REG_CENTER_X: cfg.center_x <= cfg_data;
        REG_CENTER_Y: cfg.center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  ppp_front u_front (
    .clk, .rst, .en,
    .in_valid (s_tvalid),
    .cmd      (s_tuser),
    .coord_a  (s_tdata[31:0]),
    .coord_b  (s_tdata[63:32]),
    .depth    (s_tdata[95:64]),
    .color    (s_tdata[119:96]),
    .cfg      (cfg),
    .out_valid(v[0]),
    .out_stage(st[0])
  );

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    ppp_cell u_cell (
      .clk, .rst, .en,
      .in_valid (v[i]),
      .in_stage (st[i]),
      .out_valid(v[i+1]),
      .out_stage(st[i+1])
    );
  end

  ppp_back u_back (
    .clk, .rst, .en,
    .in_valid (v[CELLS]),
    .in_stage (st[CELLS]),
    .out_valid(m_tvalid),
    .out_a    (oa),
    .out_b    (ob),
    .out_depth(od),
    .out_color(oc),
    .status   (m_tuser)
  );

  assign m_tdata = {oc, od, ob, oa};

endmodule
`default_nettype wire

// ----- rtl/ppp_checker.sv -----
// ---------------------------------------------------------------------------
// ppp_checker - port-level checks for the projection block
// ---------------------------------------------------------------------------
`default_nettype none
module ppp_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          m_tvalid,
  input wire logic          m_tready,
  input wire logic [119:0]  m_tdata,
  input wire logic [1:0]    m_tuser
);
  import ppp_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  a_zero_coords: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_ZERO |-> m_tdata[63:0] == 64'd0)
    else $error("zero depth result with non-zero coordinates");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_ZERO || m_tuser == ST_SAT)
    else $error("undefined status code");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_SAT |->
      m_tdata[31:0] == 32'h7fff_ffff || m_tdata[31:0] == 32'h8000_0000 ||
      m_tdata[63:32] == 32'h7fff_ffff || m_tdata[63:32] == 32'h8000_0000)
    else $error("saturation flagged without a clamped coordinate");

endmodule

bind pinhole_point_projection ppp_checker u_ppp_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
`default_nettype wire
